// ===== rtl/core/line_segment_rect_clipper_top_defines.svh =====
// Assertion helpers for the line segment clipper checker.
`ifndef LINE_SEGMENT_RECT_CLIPPER_TOP_DEFINES_SVH
`define LINE_SEGMENT_RECT_CLIPPER_TOP_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LSRC_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lsrc checker: assertion failed");

// next-cycle implication, off while reset is high
`define LSRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lsrc checker: assertion failed");

// next-cycle implication that also holds across reset
`define LSRC_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("lsrc checker: assertion failed");

`endif

// ===== rtl/core/lsrc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lsrc_pkg;

   typedef enum logic [1:0] {
      ST_INSIDE,
      ST_CLIPPED,
      ST_REJECTED
   } status_type;

   typedef enum logic [1:0] {
      CSR_TOP,
      CSR_BOTTOM,
      CSR_LEFT,
      CSR_RIGHT
   } csr_index_type;

   localparam int unsigned CSR_INDEX_BITS = 2;

   // reset value of the far edges (bottom, right), Q16.8
   localparam logic [31:0] EDGE_FAR_RESET = 32'd261888;

endpackage

`default_nettype wire

// ===== rtl/core/lsrc_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lsrc_window import lsrc_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  wire logic [COORD_BITS-1:0]             csr_wdata,
   output logic signed [COORD_BITS-1:0]           win_left,
   output logic signed [COORD_BITS-1:0]           win_right,
   output logic signed [COORD_BITS-1:0]           win_top,
   output logic signed [COORD_BITS-1:0]           win_bottom
);

   logic signed [COORD_BITS-1:0] top_ff;
   logic signed [COORD_BITS-1:0] bottom_ff;
   logic signed [COORD_BITS-1:0] left_ff;
   logic signed [COORD_BITS-1:0] right_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff    <= '0;
         bottom_ff <= COORD_BITS'(EDGE_FAR_RESET);
         left_ff   <= '0;
         right_ff  <= COORD_BITS'(EDGE_FAR_RESET);
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TOP:    top_ff    <= csr_wdata;
            CSR_BOTTOM: bottom_ff <= csr_wdata;
            CSR_LEFT:   left_ff   <= csr_wdata;
            CSR_RIGHT:  right_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // edges may be written in either order
   assign win_left   = (left_ff < right_ff) ? left_ff : right_ff;
   assign win_right  = (left_ff > right_ff) ? left_ff : right_ff;
   assign win_top    = (top_ff < bottom_ff) ? top_ff : bottom_ff;
   assign win_bottom = (top_ff > bottom_ff) ? top_ff : bottom_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lsrc_lerp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// result = base +/- round(m * t / den): a multiply step, then one
// quotient bit per cycle, then a rounding step. Requires t <= den.
module lsrc_lerp import lsrc_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [COORD_BITS-1:0]         m,
   input  wire logic [COORD_BITS-1:0]         t,
   input  wire logic [COORD_BITS:0]           den,
   input  wire logic                          neg,
   input  wire logic signed [COORD_BITS-1:0]  base,
   output logic                               done,
   output logic signed [COORD_BITS-1:0]       result
);

   localparam int CW    = COORD_BITS;
   localparam int CNT_W = $clog2(CW);

   typedef enum logic [1:0] {
      L_IDLE,
      L_MUL,
      L_DIV,
      L_RND
   } lerp_state_type;

   lerp_state_type           state_ff;
   logic [CW-1:0]            m_ff;
   logic [CW-1:0]            t_ff;
   logic [CW:0]              den_ff;
   logic                     neg_ff;
   logic signed [CW-1:0]     base_ff;
   logic [CW:0]              rem_ff;
   logic [CW-1:0]            quo_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     done_ff;
   logic signed [CW-1:0]     result_ff;

   logic [2*CW-1:0]          prod;
   logic [CW+1:0]            trial;
   logic                     trial_ge;
   logic [CW:0]              rem_in;
   logic [CW-1:0]            quo_in;
   logic [CW+1:0]            rem_twice;
   logic                     round_up;
   logic [CW:0]              quo_round;
   logic [CW:0]              base_wide;
   logic [CW:0]              sum;

   assign prod      = m_ff * t_ff;
   assign trial     = {rem_ff, quo_ff[CW-1]};
   assign trial_ge  = trial >= {1'b0, den_ff};
   assign rem_in    = trial_ge ? (CW+1)'(trial - {1'b0, den_ff}) : trial[CW:0];
   assign quo_in    = {quo_ff[CW-2:0], trial_ge};

   // halves go toward plus infinity
   assign rem_twice = {rem_ff, 1'b0};
   assign round_up  = neg_ff ? (rem_twice > {1'b0, den_ff})
                             : (rem_twice >= {1'b0, den_ff});
   assign quo_round = {1'b0, quo_ff} + (CW+1)'(round_up);
   assign base_wide = {base_ff[CW-1], base_ff};
   assign sum       = neg_ff ? (base_wide - quo_round) : (base_wide + quo_round);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            L_IDLE: begin
               if (start) begin
                  m_ff     <= m;
                  t_ff     <= t;
                  den_ff   <= den;
                  neg_ff   <= neg;
                  base_ff  <= base;
                  state_ff <= L_MUL;
               end
            end
            L_MUL: begin
               // high half is already below den, so CW quotient bits suffice
               rem_ff   <= {1'b0, prod[2*CW-1:CW]};
               quo_ff   <= prod[CW-1:0];
               cnt_ff   <= CNT_W'(CW-1);
               state_ff <= L_DIV;
            end
            L_DIV: begin
               rem_ff <= rem_in;
               quo_ff <= quo_in;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= L_RND;
               end
            end
            L_RND: begin
               result_ff <= sum[CW-1:0];
               done_ff   <= 1'b1;
               state_ff  <= L_IDLE;
            end
            default: state_ff <= L_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/line_segment_rect_clipper_top.sv =====
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  req_operation, req_point_x, req_point_y
// rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_start_x/y, rsp_end_x/y
// csr      in         csr_wr_en            csr_index, csr_wdata
//
// A move only updates the pen and leaves the block idle. A draw runs a trivial-reject check,
// then each plane in turn; a plane that cuts the segment waits on the shared lerp divider,
// which produces one quotient bit per cycle.
// req_stall is high from a draw transfer until its result sits in the output register.
// A waiting result does not block the next transfer on req.
// Reset is synchronous; it restores the window edges and clears the pen to zero.
`timescale 1ns / 1ps
`default_nettype none

module line_segment_rect_clipper_top import lsrc_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_operation,
   input  wire logic signed [COORD_BITS-1:0]      req_point_x,
   input  wire logic signed [COORD_BITS-1:0]      req_point_y,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [1:0]                             rsp_status,
   output logic signed [COORD_BITS-1:0]           rsp_start_x,
   output logic signed [COORD_BITS-1:0]           rsp_start_y,
   output logic signed [COORD_BITS-1:0]           rsp_end_x,
   output logic signed [COORD_BITS-1:0]           rsp_end_y,
   input  wire logic                              csr_wr_en,
   input  wire logic [CSR_INDEX_BITS-1:0]         csr_index,
   input  wire logic [COORD_BITS-1:0]             csr_wdata
);

   localparam int CW = COORD_BITS;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIV,
      S_EVAL,
      S_SETUP,
      S_CALC,
      S_DONE
   } state_type;

   typedef enum logic [1:0] {
      PL_LEFT,
      PL_RIGHT,
      PL_TOP,
      PL_BOTTOM
   } plane_type;

   state_type             state_ff;
   plane_type             plane_ff;
   logic signed [CW-1:0]  pen_x_ff;
   logic signed [CW-1:0]  pen_y_ff;
   logic signed [CW-1:0]  ax_ff;
   logic signed [CW-1:0]  ay_ff;
   logic signed [CW-1:0]  bx_ff;
   logic signed [CW-1:0]  by_ff;
   logic [CW:0]           ka_ff;
   logic [CW:0]           kb_ff;
   logic                  out_is_a_ff;
   logic                  clipped_ff;
   logic                  rejected_ff;
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic signed [CW-1:0]  rsp_start_x_ff;
   logic signed [CW-1:0]  rsp_start_y_ff;
   logic signed [CW-1:0]  rsp_end_x_ff;
   logic signed [CW-1:0]  rsp_end_y_ff;

   logic signed [CW-1:0]  win_left;
   logic signed [CW-1:0]  win_right;
   logic signed [CW-1:0]  win_top;
   logic signed [CW-1:0]  win_bottom;

   logic signed [CW-1:0]  edge_sel;
   logic                  axis_y;
   logic                  pos_side;
   logic signed [CW-1:0]  pa_c;
   logic signed [CW-1:0]  pb_c;
   logic [CW:0]           edge_w;
   logic [CW:0]           pa_w;
   logic [CW:0]           pb_w;
   logic [CW:0]           ka_calc;
   logic [CW:0]           kb_calc;
   logic                  trivial_reject;

   logic                  ka_neg;
   logic                  kb_neg;
   logic                  out_is_a;
   logic [CW:0]           k_in;
   logic [CW:0]           k_out;
   logic [CW:0]           den_calc;
   logic [CW:0]           t_full;
   logic signed [CW-1:0]  in_other;
   logic signed [CW-1:0]  out_other;
   logic [CW:0]           diff;
   logic [CW:0]           diff_abs;
   logic                  lerp_start;
   logic                  lerp_done;
   logic signed [CW-1:0]  lerp_result;
   logic                  rsp_free;

   lsrc_window #(
      .COORD_BITS (CW)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .win_left   (win_left),
      .win_right  (win_right),
      .win_top    (win_top),
      .win_bottom (win_bottom)
   );

   always_comb begin
      case (plane_ff)
         PL_LEFT:   edge_sel = win_left;
         PL_RIGHT:  edge_sel = win_right;
         PL_TOP:    edge_sel = win_top;
         PL_BOTTOM: edge_sel = win_bottom;
         default:   edge_sel = win_left;
      endcase
   end

   assign axis_y   = (plane_ff == PL_TOP) || (plane_ff == PL_BOTTOM);
   assign pos_side = (plane_ff == PL_RIGHT) || (plane_ff == PL_BOTTOM);
   assign pa_c     = axis_y ? ay_ff : ax_ff;
   assign pb_c     = axis_y ? by_ff : bx_ff;
   assign edge_w   = {edge_sel[CW-1], edge_sel};
   assign pa_w     = {pa_c[CW-1], pa_c};
   assign pb_w     = {pb_c[CW-1], pb_c};
   // distance beyond the plane; negative means strictly inside
   assign ka_calc  = pos_side ? (pa_w - edge_w) : (edge_w - pa_w);
   assign kb_calc  = pos_side ? (pb_w - edge_w) : (edge_w - pb_w);

   assign trivial_reject = (ax_ff < win_left && bx_ff < win_left)
                        || (ax_ff > win_right && bx_ff > win_right)
                        || (ay_ff < win_top && by_ff < win_top)
                        || (ay_ff > win_bottom && by_ff > win_bottom);

   assign ka_neg    = ka_ff[CW];
   assign kb_neg    = kb_ff[CW];
   assign out_is_a  = !ka_neg;
   assign k_in      = out_is_a ? kb_ff : ka_ff;
   assign k_out     = out_is_a ? ka_ff : kb_ff;
   assign den_calc  = k_out - k_in;
   assign t_full    = -k_in;
   // coordinate across the plane's axis, the one that gets interpolated
   assign in_other  = axis_y ? (out_is_a ? bx_ff : ax_ff) : (out_is_a ? by_ff : ay_ff);
   assign out_other = axis_y ? (out_is_a ? ax_ff : bx_ff) : (out_is_a ? ay_ff : by_ff);
   assign diff      = {out_other[CW-1], out_other} - {in_other[CW-1], in_other};
   assign diff_abs  = diff[CW] ? -diff : diff;
   assign lerp_start = (state_ff == S_SETUP) && (ka_neg != kb_neg);

   lsrc_lerp #(
      .COORD_BITS (CW)
   ) u_lerp (
      .clock  (clock),
      .reset  (reset),
      .start  (lerp_start),
      .m      (diff_abs[CW-1:0]),
      .t      (t_full[CW-1:0]),
      .den    (den_calc),
      .neg    (diff[CW]),
      .base   (in_other),
      .done   (lerp_done),
      .result (lerp_result)
   );

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         plane_ff     <= PL_LEFT;
         pen_x_ff     <= '0;
         pen_y_ff     <= '0;
         clipped_ff   <= 1'b0;
         rejected_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // in S_DONE the next result takes the slot instead
         if (rsp_valid_ff && !rsp_stall && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  pen_x_ff <= req_point_x;
                  pen_y_ff <= req_point_y;
                  if (req_operation) begin
                     ax_ff       <= pen_x_ff;
                     ay_ff       <= pen_y_ff;
                     bx_ff       <= req_point_x;
                     by_ff       <= req_point_y;
                     clipped_ff  <= 1'b0;
                     rejected_ff <= 1'b0;
                     state_ff    <= S_TRIV;
                  end
               end
            end
            S_TRIV: begin
               plane_ff <= PL_LEFT;
               if (trivial_reject) begin
                  rejected_ff <= 1'b1;
                  state_ff    <= S_DONE;
               end else begin
                  state_ff <= S_EVAL;
               end
            end
            S_EVAL: begin
               ka_ff    <= ka_calc;
               kb_ff    <= kb_calc;
               state_ff <= S_SETUP;
            end
            S_SETUP: begin
               if (!ka_neg && !kb_neg) begin
                  rejected_ff <= 1'b1;
                  state_ff    <= S_DONE;
               end else if (ka_neg && kb_neg) begin
                  if (plane_ff == PL_BOTTOM) begin
                     state_ff <= S_DONE;
                  end else begin
                     plane_ff <= plane_type'(plane_ff + 1'b1);
                     state_ff <= S_EVAL;
                  end
               end else begin
                  // outside end lands exactly on the edge
                  clipped_ff  <= 1'b1;
                  out_is_a_ff <= out_is_a;
                  case ({axis_y, out_is_a})
                     2'b00:   bx_ff <= edge_sel;
                     2'b01:   ax_ff <= edge_sel;
                     2'b10:   by_ff <= edge_sel;
                     2'b11:   ay_ff <= edge_sel;
                     default: ;
                  endcase
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               if (lerp_done) begin
                  case ({axis_y, out_is_a_ff})
                     2'b00:   by_ff <= lerp_result;
                     2'b01:   ay_ff <= lerp_result;
                     2'b10:   bx_ff <= lerp_result;
                     2'b11:   ax_ff <= lerp_result;
                     default: ;
                  endcase
                  if (plane_ff == PL_BOTTOM) begin
                     state_ff <= S_DONE;
                  end else begin
                     plane_ff <= plane_type'(plane_ff + 1'b1);
                     state_ff <= S_EVAL;
                  end
               end
            end
            S_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (rejected_ff) begin
                     rsp_status_ff  <= ST_REJECTED;
                     rsp_start_x_ff <= '0;
                     rsp_start_y_ff <= '0;
                     rsp_end_x_ff   <= '0;
                     rsp_end_y_ff   <= '0;
                  end else begin
                     rsp_status_ff  <= clipped_ff ? ST_CLIPPED : ST_INSIDE;
                     rsp_start_x_ff <= ax_ff;
                     rsp_start_y_ff <= ay_ff;
                     rsp_end_x_ff   <= bx_ff;
                     rsp_end_y_ff   <= by_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_start_x = rsp_start_x_ff;
   assign rsp_start_y = rsp_start_y_ff;
   assign rsp_end_x   = rsp_end_x_ff;
   assign rsp_end_y   = rsp_end_y_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lsrc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "line_segment_rect_clipper_top_defines.svh"

module lsrc_checker import lsrc_pkg::*; #(
   parameter int COORD_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_stall,
   input  wire logic                          req_operation,
   input  wire logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic [1:0]                    rsp_status,
   input  wire logic signed [COORD_BITS-1:0]  rsp_start_x,
   input  wire logic signed [COORD_BITS-1:0]  rsp_start_y,
   input  wire logic signed [COORD_BITS-1:0]  rsp_end_x,
   input  wire logic signed [COORD_BITS-1:0]  rsp_end_y
);

   logic [4*COORD_BITS+1:0] rsp_bundle;
   logic                    rsp_ends_zero;

   assign rsp_bundle    = {rsp_status, rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y};
   assign rsp_ends_zero = (rsp_start_x == '0) && (rsp_start_y == '0)
                       && (rsp_end_x == '0) && (rsp_end_y == '0);

   // a result waiting on a stall keeps its status and endpoints
   `LSRC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_bundle))

   // a rejected segment reports zero endpoints
   `LSRC_ASSERT_HOLDS(a_reject_zero, clock, reset, rsp_valid && rsp_status == ST_REJECTED, rsp_ends_zero)

   // a draw transfer keeps the block busy in the following cycle
   `LSRC_ASSERT_NEXT(a_draw_busy, clock, reset, req_valid && !req_stall && req_operation, req_stall)

   // reset leaves no result pending and the input open
   `LSRC_ASSERT_ALWAYS_NEXT(a_reset_clear, clock, reset, !rsp_valid && !req_stall)

endmodule

bind line_segment_rect_clipper_top lsrc_checker #(
   .COORD_BITS (COORD_BITS)
) u_lsrc_checker (.*);

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import lsrc_pkg::*;

   localparam int CW = 24;
   localparam longint CMIN_L = -(64'sd1 <<< (CW - 1));
   localparam longint CMAX_L = (64'sd1 <<< (CW - 1)) - 1;
   localparam logic [CW-1:0] CMIN = CW'(CMIN_L);
   localparam logic [CW-1:0] CMAX = CW'(CMAX_L);
   localparam logic [CW-1:0] FAR_EDGE = EDGE_FAR_RESET[CW-1:0];
   localparam logic OP_MOVE = 1'b0;
   localparam logic OP_DRAW = 1'b1;
   localparam int SETTLE = 200;
   localparam int NUM_PHASES = 13;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int NUM_DIRECTED = 25;
   localparam longint TIMEOUT_NS = 15_000_000;

   typedef struct packed {
      status_type    status;
      logic [CW-1:0] sx;
      logic [CW-1:0] sy;
      logic [CW-1:0] ex;
      logic [CW-1:0] ey;
   } seg_result_type;

   typedef struct packed {
      logic           op;
      logic [CW-1:0]  x;
      logic [CW-1:0]  y;
      logic           typed;
      seg_result_type want;
   } stim_row_type;

   localparam seg_result_type NO_RESULT = '{ST_INSIDE, '0, '0, '0, '0};
   localparam seg_result_type REJECT_RESULT = '{ST_REJECTED, '0, '0, '0, '0};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_operation = 1'b0;
   logic signed [CW-1:0] req_point_x = '0;
   logic signed [CW-1:0] req_point_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_status;
   logic signed [CW-1:0] rsp_start_x;
   logic signed [CW-1:0] rsp_start_y;
   logic signed [CW-1:0] rsp_end_x;
   logic signed [CW-1:0] rsp_end_y;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CW-1:0]        csr_wdata = '0;

   line_segment_rect_clipper_top #(.COORD_BITS(CW)) u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_operation(req_operation),
      .req_point_x  (req_point_x),
      .req_point_y  (req_point_y),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_start_x  (rsp_start_x),
      .rsp_start_y  (rsp_start_y),
      .rsp_end_x    (rsp_end_x),
      .rsp_end_y    (rsp_end_y),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state: window edges as written, and the pen
   logic signed [CW-1:0] window_edge [4];
   logic signed [CW-1:0] pen_x_pred;
   logic signed [CW-1:0] pen_y_pred;

   seg_result_type expected_segments [$];
   int             fail_count = 0;
   int             gap_pct = 0;
   int             stall_pct = 0;
   int             rsp_hold_left = 0;
   stim_row_type   dir_rows [NUM_DIRECTED];

   initial begin
      window_edge[CSR_TOP]    = '0;
      window_edge[CSR_BOTTOM] = FAR_EDGE;
      window_edge[CSR_LEFT]   = '0;
      window_edge[CSR_RIGHT]  = FAR_EDGE;
      pen_x_pred = '0;
      pen_y_pred = '0;
   end

   function automatic longint edge_min(input csr_index_type p, input csr_index_type q);
      return (window_edge[p] < window_edge[q]) ? window_edge[p] : window_edge[q];
   endfunction

   function automatic longint edge_max(input csr_index_type p, input csr_index_type q);
      return (window_edge[p] > window_edge[q]) ? window_edge[p] : window_edge[q];
   endfunction

   // a + round((b - a) * t / den), halves toward plus infinity
   function automatic longint lerp_near(input longint a, input longint b, input longint t,
                                        input longint den);
      longint d, m, p, q, r;
      d = b - a;
      m = (d < 0) ? -d : d;
      p = m * t;
      q = p / den;
      r = p % den;
      if (d < 0) begin
         if (2 * r > den) q = q + 1;
         return a - q;
      end
      if (2 * r >= den) q = q + 1;
      return a + q;
   endfunction

   // returns 1 when the item gives a result; updates the pen
   function automatic bit clip_against_window(input logic op, input logic signed [CW-1:0] px,
                                              input logic signed [CW-1:0] py,
                                              output seg_result_type res);
      longint a [2];
      longint b [2];
      longint bound [4];
      longint ka, kb, den, t;
      bit clipped, rejected, upper;
      int axis;
      res = NO_RESULT;
      if (op == OP_MOVE) begin
         pen_x_pred = px;
         pen_y_pred = py;
         return 1'b0;
      end
      a[0] = pen_x_pred;
      a[1] = pen_y_pred;
      b[0] = px;
      b[1] = py;
      pen_x_pred = px;
      pen_y_pred = py;
      // plane order: left, right, top, bottom
      bound[0] = edge_min(CSR_LEFT, CSR_RIGHT);
      bound[1] = edge_max(CSR_LEFT, CSR_RIGHT);
      bound[2] = edge_min(CSR_TOP, CSR_BOTTOM);
      bound[3] = edge_max(CSR_TOP, CSR_BOTTOM);
      clipped = 1'b0;
      rejected = (a[0] < bound[0] && b[0] < bound[0]) || (a[0] > bound[1] && b[0] > bound[1]) ||
                 (a[1] < bound[2] && b[1] < bound[2]) || (a[1] > bound[3] && b[1] > bound[3]);
      for (int pl = 0; pl < 4; pl++) begin
         if (!rejected) begin
            axis = pl / 2;
            upper = (pl % 2) == 1;
            // k >= 0 means outside this plane (on the edge counts as outside)
            ka = upper ? a[axis] - bound[pl] : bound[pl] - a[axis];
            kb = upper ? b[axis] - bound[pl] : bound[pl] - b[axis];
            if (ka >= 0 && kb >= 0) begin
               rejected = 1'b1;
            end else if (ka >= 0) begin
               clipped = 1'b1;
               den = ka - kb;
               t = -kb;
               for (int i = 0; i < 2; i++) a[i] = lerp_near(b[i], a[i], t, den);
            end else if (kb >= 0) begin
               clipped = 1'b1;
               den = kb - ka;
               t = -ka;
               for (int i = 0; i < 2; i++) b[i] = lerp_near(a[i], b[i], t, den);
            end
         end
      end
      if (rejected) begin
         res = REJECT_RESULT;
      end else begin
         res.status = clipped ? ST_CLIPPED : ST_INSIDE;
         res.sx = CW'(a[0]);
         res.sy = CW'(a[1]);
         res.ex = CW'(b[0]);
         res.ey = CW'(b[1]);
      end
      return 1'b1;
   endfunction

   // mostly around the window, some on the edges, some anywhere
   function automatic logic signed [CW-1:0] pick_coord(input longint lo, input longint hi);
      longint span, v;
      int unsigned sel;
      span = hi - lo;
      if (span < 64) span = 64;
      sel = $urandom_range(99, 0);
      if (sel < 55) v = lo - span / 4 + longint'($urandom_range(32'(span + span / 2), 0));
      else if (sel < 70) v = lo + longint'($urandom_range(2, 0)) - 1;
      else if (sel < 85) v = hi + longint'($urandom_range(2, 0)) - 1;
      else v = longint'($signed(CW'($urandom)));
      if (v < CMIN_L) v = CMIN_L;
      if (v > CMAX_L) v = CMAX_L;
      return CW'(v);
   endfunction

   task automatic report_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endtask

   // drive one item and hold it until the transfer; returns at the accepting edge
   task automatic send_item(input logic op, input logic signed [CW-1:0] px,
                            input logic signed [CW-1:0] py, input logic typed,
                            input seg_result_type typed_res);
      seg_result_type res;
      bit has_res;
      req_valid <= 1'b1;
      req_operation <= op;
      req_point_x <= px;
      req_point_y <= py;
      do @(posedge clock); while (req_stall !== 1'b0);
      has_res = clip_against_window(op, px, py, res);
      if (has_res) expected_segments.push_back(typed ? typed_res : res);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_segments.size() != 0) @(posedge clock);
      // a trailing move may still be in flight
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CW-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      window_edge[idx] = value;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left <= 0;
      end else if (rsp_hold_left != 0) begin
         rsp_hold_left <= rsp_hold_left - 1;
      end else if ($urandom_range(99, 0) < stall_pct) begin
         rsp_stall <= 1'b1;
         rsp_hold_left <= $urandom_range(11, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      seg_result_type want;
      seg_result_type got;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         got = '{status_type'(rsp_status), rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y};
         if (expected_segments.size() == 0) begin
            report_failure($sformatf("unexpected result: status %0d start (%0d,%0d) end (%0d,%0d)",
                           got.status, $signed(got.sx), $signed(got.sy), $signed(got.ex),
                           $signed(got.ey)));
         end else begin
            want = expected_segments.pop_front();
            if (got !== want)
               report_failure($sformatf({"result mismatch: expected status %0d start (%0d,%0d) ",
                              "end (%0d,%0d), got status %0d start (%0d,%0d) end (%0d,%0d)"},
                              want.status, $signed(want.sx), $signed(want.sy),
                              $signed(want.ex), $signed(want.ey), rsp_status,
                              rsp_start_x, rsp_start_y, rsp_end_x, rsp_end_y));
         end
      end
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      longint c [4];
      longint mid, half;
      int mode, pair;
      logic op;
      logic signed [CW-1:0] px, py;

      // directed part, default window (0 .. FAR_EDGE); pen starts at the corner
      dir_rows = '{
         '{OP_DRAW, 24'd1000, 24'd1000, 1'b0, NO_RESULT},
         '{OP_MOVE, 24'd256, 24'd256, 1'b0, NO_RESULT},
         '{OP_DRAW, 24'd2560, 24'd2560, 1'b1,
           '{ST_INSIDE, 24'd256, 24'd256, 24'd2560, 24'd2560}},
         '{OP_DRAW, CMIN, 24'd2560, 1'b0, NO_RESULT},
         '{OP_MOVE, CMIN, CMIN, 1'b0, NO_RESULT},
         '{OP_DRAW, CMAX, CMAX, 1'b0, NO_RESULT},
         '{OP_DRAW, CMAX, CMIN, 1'b1, REJECT_RESULT},
         '{OP_DRAW, CMIN, CMAX, 1'b0, NO_RESULT},
         '{OP_DRAW, -24'sd1000, 24'd1000, 1'b1, REJECT_RESULT},
         // segments lying on each edge
         '{OP_MOVE, 24'd0, 24'd500, 1'b0, NO_RESULT},
         '{OP_DRAW, 24'd0, 24'd600, 1'b1, REJECT_RESULT},
         '{OP_MOVE, FAR_EDGE, 24'd100, 1'b0, NO_RESULT},
         '{OP_DRAW, FAR_EDGE, 24'd200, 1'b1, REJECT_RESULT},
         '{OP_MOVE, 24'd100, 24'd0, 1'b0, NO_RESULT},
         '{OP_DRAW, 24'd200, 24'd0, 1'b1, REJECT_RESULT},
         '{OP_MOVE, 24'd100, FAR_EDGE, 1'b0, NO_RESULT},
         '{OP_DRAW, 24'd200, FAR_EDGE, 1'b1, REJECT_RESULT},
         '{OP_MOVE, 24'd1, 24'd1, 1'b0, NO_RESULT},
         '{OP_DRAW, FAR_EDGE - 24'd1, FAR_EDGE - 24'd1, 1'b1,
           '{ST_INSIDE, 24'd1, 24'd1, FAR_EDGE - 24'd1, FAR_EDGE - 24'd1}},
         '{OP_MOVE, -24'sd1, 24'd300, 1'b0, NO_RESULT},
         '{OP_DRAW, 24'd300, -24'sd1, 1'b0, NO_RESULT},
         // exact halves, rounding up and down
         '{OP_MOVE, 24'd1, 24'd1, 1'b0, NO_RESULT},
         '{OP_DRAW, -24'sd1, 24'd2, 1'b0, NO_RESULT},
         '{OP_MOVE, 24'd1, 24'd2, 1'b0, NO_RESULT},
         '{OP_DRAW, -24'sd1, 24'd1, 1'b0, NO_RESULT}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      gap_pct = 25;
      stall_pct = 25;
      foreach (dir_rows[k]) begin
         send_item(dir_rows[k].op, dir_rows[k].x, dir_rows[k].y, dir_rows[k].typed,
                   dir_rows[k].want);
         if ($urandom_range(99, 0) < gap_pct) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(12, 1)) @(posedge clock);
         end
      end

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         drain_results();
         mode = (phase < 6) ? phase : $urandom_range(5, 0);
         case (mode)
            0: begin
               c[0] = 0;
               c[1] = FAR_EDGE;
               c[2] = 0;
               c[3] = FAR_EDGE;
            end
            1: begin
               // full range, pairs written in swapped order
               c[0] = CMAX_L;
               c[1] = CMIN_L;
               c[2] = CMAX_L;
               c[3] = CMIN_L;
            end
            4: begin
               for (int k = 0; k < 4; k++) c[k] = longint'($signed(CW'($urandom)));
            end
            default: begin
               for (int k = 0; k < 2; k++) begin
                  mid = longint'($urandom_range(1 << 21, 0)) - (1 << 20);
                  half = (mode == 5) ? $urandom_range(2, 1) : $urandom_range(1 << 16, 1);
                  if ($urandom_range(1, 0)) begin
                     c[2 * k] = mid + half;
                     c[2 * k + 1] = mid;
                  end else begin
                     c[2 * k] = mid;
                     c[2 * k + 1] = mid + half;
                  end
               end
               if (mode == 3) begin
                  // one pair collapsed: nothing is strictly inside
                  pair = $urandom_range(1, 0);
                  c[2 * pair + 1] = c[2 * pair];
               end
            end
         endcase
         for (int k = 0; k < 4; k++) write_csr(csr_index_type'(k), CW'(c[k]));
         csr_wr_en <= 1'b0;

         if (phase == NUM_PHASES - 1) begin
            gap_pct = 0;
            stall_pct = 0;
         end else begin
            case ($urandom_range(2, 0))
               0: gap_pct = 0;
               1: gap_pct = 8;
               default: gap_pct = 30;
            endcase
            case ($urandom_range(2, 0))
               0: stall_pct = 0;
               1: stall_pct = 8;
               default: stall_pct = 30;
            endcase
         end

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            op = ($urandom_range(99, 0) < 75) ? OP_DRAW : OP_MOVE;
            px = pick_coord(edge_min(CSR_LEFT, CSR_RIGHT), edge_max(CSR_LEFT, CSR_RIGHT));
            py = pick_coord(edge_min(CSR_TOP, CSR_BOTTOM), edge_max(CSR_TOP, CSR_BOTTOM));
            // axis-aligned segments now and then
            if ($urandom_range(9, 0) == 0) px = pen_x_pred;
            else if ($urandom_range(9, 0) == 0) py = pen_y_pred;
            send_item(op, px, py, 1'b0, NO_RESULT);
            if ($urandom_range(99, 0) < gap_pct) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(12, 1)) @(posedge clock);
            end else if (phase != NUM_PHASES - 1 && $urandom_range(199, 0) == 0) begin
               drain_results();
            end
         end
      end

      drain_results();
      if (fail_count == 0 && expected_segments.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
